>>> hw/rtl/xtl_pkg.sv
package xtl_pkg;

  // Sample and result field widths
  localparam int SW = 16;
  localparam int OW = 16;

  // Configuration port
  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_WHITE_X = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WHITE_Z = 8'd1;
  localparam logic [SW-1:0] WHITE_X_RST = 16'd24332;
  localparam logic [SW-1:0] WHITE_Z_RST = 16'd27874;

  // Divider: 64-bit quotient, two quotient bits per stage
  localparam int QW          = 64;
  localparam int DIV_BPS     = 2;
  localparam int DIV_STAGES  = QW / DIV_BPS;

  // Cube root: one root bit (three radicand bits) per stage
  localparam int RW          = 22;
  localparam int CBRT_STAGES = RW;
  localparam int CREM_W      = 50;
  localparam int YSQ_W       = 2 * RW;

  // Output stages: scale, then round and saturate
  localparam int LAB_STAGES  = 2;
  localparam int VW          = 34;

endpackage

>>> hw/rtl/xtl_div.sv
module xtl_div import xtl_pkg::*; #(
  parameter int DW = 28
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [QW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic          lin_i,
  output logic [QW-1:0] quo_o,
  output logic          lin_o
);

  // nq holds the numerator bits still to come above the quotient bits so far
  logic [QW-1:0] nq_s   [DIV_STAGES];
  logic [DW-1:0] rem_s  [DIV_STAGES];
  logic [DW-1:0] den_s  [DIV_STAGES];
  logic          lin_s  [DIV_STAGES];
  logic [QW-1:0] nq_d   [DIV_STAGES];
  logic [DW-1:0] rem_d  [DIV_STAGES];
  logic [QW-1:0] nq_q   [DIV_STAGES];
  logic [DW-1:0] rem_q  [DIV_STAGES];
  logic [DW-1:0] den_q  [DIV_STAGES];
  logic          lin_q  [DIV_STAGES];

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
    // stage source
    if (g == 0) begin : g_first
      assign nq_s[g]  = num_i;
      assign rem_s[g] = '0;
      assign den_s[g] = den_i;
      assign lin_s[g] = lin_i;
    end else begin : g_next
      assign nq_s[g]  = nq_q[g-1];
      assign rem_s[g] = rem_q[g-1];
      assign den_s[g] = den_q[g-1];
      assign lin_s[g] = lin_q[g-1];
    end

    // restoring division, DIV_BPS bits
    always_comb begin
      logic [QW-1:0] nq;
      logic [DW-1:0] rem;
      logic [DW:0]   trial;
      nq  = nq_s[g];
      rem = rem_s[g];
      for (int b = 0; b < DIV_BPS; b++) begin
        trial = {rem, nq[QW-1]};
        nq    = nq << 1;
        if (trial >= {1'b0, den_s[g]}) begin
          rem   = DW'(trial - {1'b0, den_s[g]});
          nq[0] = 1'b1;
        end else begin
          rem   = trial[DW-1:0];
        end
      end
      nq_d[g]  = nq;
      rem_d[g] = rem;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        nq_q[g]  <= nq_d[g];
        rem_q[g] <= rem_d[g];
        den_q[g] <= den_s[g];
        lin_q[g] <= lin_s[g];
      end
    end
  end

  assign quo_o = nq_q[DIV_STAGES-1];
  assign lin_o = lin_q[DIV_STAGES-1];

endmodule

>>> hw/rtl/xtl_cbrt.sv
module xtl_cbrt import xtl_pkg::*; (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [QW-1:0] rad_i,
  input  logic          lin_i,
  output logic [RW-1:0] f_o
);

  localparam int PW = 3 * RW;

  logic [PW-1:0]     rad_s [CBRT_STAGES];
  logic [CREM_W-1:0] rem_s [CBRT_STAGES];
  logic [RW-1:0]     y_s   [CBRT_STAGES];
  logic [YSQ_W-1:0]  ysq_s [CBRT_STAGES];
  logic              lin_s [CBRT_STAGES];
  logic [RW-1:0]     lv_s  [CBRT_STAGES];
  logic [CREM_W-1:0] rem_d [CBRT_STAGES];
  logic [RW-1:0]     y_d   [CBRT_STAGES];
  logic [YSQ_W-1:0]  ysq_d [CBRT_STAGES];
  logic [PW-1:0]     rad_q [CBRT_STAGES];
  logic [CREM_W-1:0] rem_q [CBRT_STAGES];
  logic [RW-1:0]     y_q   [CBRT_STAGES];
  logic [YSQ_W-1:0]  ysq_q [CBRT_STAGES];
  logic              lin_q [CBRT_STAGES];
  logic [RW-1:0]     lv_q  [CBRT_STAGES];

  for (genvar g = 0; g < CBRT_STAGES; g++) begin : g_stage
    if (g == 0) begin : g_first
      assign rad_s[g] = PW'(rad_i);
      assign rem_s[g] = '0;
      assign y_s[g]   = '0;
      assign ysq_s[g] = '0;
      assign lin_s[g] = lin_i;
      assign lv_s[g]  = rad_i[RW-1:0];
    end else begin : g_next
      assign rad_s[g] = rad_q[g-1] << 3;
      assign rem_s[g] = rem_q[g-1];
      assign y_s[g]   = y_q[g-1];
      assign ysq_s[g] = ysq_q[g-1];
      assign lin_s[g] = lin_q[g-1];
      assign lv_s[g]  = lv_q[g-1];
    end

    // one root digit: trial 3(2y)^2 + 3(2y) + 1 = 12y^2 + 6y + 1
    always_comb begin
      logic [CREM_W-1:0] remn;
      logic [CREM_W-1:0] trial;
      logic [CREM_W-1:0] yx;
      logic [CREM_W-1:0] sx;
      yx    = CREM_W'(y_s[g]);
      sx    = CREM_W'(ysq_s[g]);
      remn  = {rem_s[g][CREM_W-4:0], rad_s[g][PW-1 -: 3]};
      trial = (sx << 3) + (sx << 2) + (yx << 2) + (yx << 1) + CREM_W'(1);
      if (remn >= trial) begin
        rem_d[g] = remn - trial;
        y_d[g]   = {y_s[g][RW-2:0], 1'b1};
        ysq_d[g] = (ysq_s[g] << 2) + (YSQ_W'(y_s[g]) << 2) + YSQ_W'(1);
      end else begin
        rem_d[g] = remn;
        y_d[g]   = {y_s[g][RW-2:0], 1'b0};
        ysq_d[g] = ysq_s[g] << 2;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[g] <= rad_s[g];
        rem_q[g] <= rem_d[g];
        y_q[g]   <= y_d[g];
        ysq_q[g] <= ysq_d[g];
        lin_q[g] <= lin_s[g];
        lv_q[g]  <= lv_s[g];
      end
    end
  end

  // linear segment bypasses the root
  assign f_o = lin_q[CBRT_STAGES-1] ? lv_q[CBRT_STAGES-1] : y_q[CBRT_STAGES-1];

endmodule

>>> hw/rtl/xtl_lab.sv
module xtl_lab import xtl_pkg::*; #(
  parameter int FRAC_BITS = 8
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [RW-1:0]        fx_i,
  input  logic [RW-1:0]        fy_i,
  input  logic [RW-1:0]        fz_i,
  output logic signed [OW-1:0] l_o,
  output logic signed [OW-1:0] a_o,
  output logic signed [OW-1:0] b_o
);

  localparam int SH = 16 - FRAC_BITS;
  localparam logic signed [VW-1:0] RND =
    (SH > 0) ? VW'(64'd1 << ((SH > 0) ? SH - 1 : 0)) : '0;
  localparam logic signed [VW-1:0] OFS_L = VW'(64'd16 << 16);
  localparam logic signed [VW-1:0] SMAX  = VW'(32767);
  localparam logic signed [VW-1:0] SMIN  = -VW'(32768);

  logic signed [VW-1:0] fxs, fys, fzs;
  logic signed [VW-1:0] l_d, a_d, b_d;
  logic signed [VW-1:0] l_q, a_q, b_q;
  logic signed [OW-1:0] lo_q, ao_q, bo_q;

  function automatic logic signed [OW-1:0] rnd_sat(input logic signed [VW-1:0] v);
    logic signed [VW-1:0] t;
    t = (v + RND) >>> SH;
    if (t > SMAX)      rnd_sat = OW'(SMAX);
    else if (t < SMIN) rnd_sat = OW'(SMIN);
    else               rnd_sat = t[OW-1:0];
  endfunction

  assign fxs = $signed({{(VW-RW){1'b0}}, fx_i});
  assign fys = $signed({{(VW-RW){1'b0}}, fy_i});
  assign fzs = $signed({{(VW-RW){1'b0}}, fz_i});

  // Q16 scaling by the CIELAB weights
  assign l_d = fys * VW'(116) - OFS_L;
  assign a_d = (fxs - fys) * VW'(500);
  assign b_d = (fys - fzs) * VW'(200);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      l_q  <= l_d;
      a_q  <= a_d;
      b_q  <= b_d;
      lo_q <= rnd_sat(l_q);
      ao_q <= rnd_sat(a_q);
      bo_q <= rnd_sat(b_q);
    end
  end

  assign l_o = lo_q;
  assign a_o = ao_q;
  assign b_o = bo_q;

endmodule

>>> hw/rtl/xyz_to_lab_core.sv
// CIE XYZ to CIELAB converter. Takes one unsigned Q8.8 (FRAC_BITS) XYZ beat per
// clock and returns L*, a*, b* as signed saturated values with the same fraction
// bits, in input order. It is built of two set-up stages, a 32-stage
// divider (two quotient bits per stage) per channel, a 22-stage cube root (one
// root bit per stage) and two scale/round stages. Throughput is one beat per
// cycle; a stalled output holds the whole pipeline. White X and Z are written
// through the configuration port (index 0 and 1, a value of 0 acts as 1) and
// must only change while no beat is in flight; white Y is fixed at 100.
module xyz_to_lab_core import xtl_pkg::*; #(
  parameter int FRAC_BITS = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [SW-1:0]        sample_x_i,
  input  logic [SW-1:0]        sample_y_i,
  input  logic [SW-1:0]        sample_z_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic signed [OW-1:0] lightness_o,
  output logic signed [OW-1:0] red_green_o,
  output logic signed [OW-1:0] yellow_blue_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [SW-1:0]        cfg_data_i
);

  localparam int WYW = 7 + FRAC_BITS;
  localparam int WW  = (WYW > SW) ? WYW : SW;
  localparam int DW  = WW + 12;
  localparam int LAT = 2 + DIV_STAGES + CBRT_STAGES + LAB_STAGES;
  localparam logic [WW-1:0] WHITE_Y = WW'(100) << FRAC_BITS;

  logic            adv;
  logic [LAT-1:0]  vld_q;
  logic [SW-1:0]   white_x_q, white_z_q;

  logic [SW-1:0]   smp  [3];
  logic [WW-1:0]   wht  [3];
  logic [SW-1:0]   s_q  [3];
  logic [30:0]     ps_q [3];
  logic [WW+7:0]   p216_q [3];
  logic [WW+8:0]   p432_q [3];
  logic [DW-1:0]   p3132_q [3];
  logic [WW-1:0]   w_q  [3];
  logic [QW-1:0]   num_q [3];
  logic [DW-1:0]   den_q [3];
  logic            lin_q [3];
  logic [QW-1:0]   quo  [3];
  logic            dlin [3];
  logic [RW-1:0]   f    [3];

  // whole pipeline moves unless a finished beat is held at the output
  assign adv         = !vld_q[LAT-1] || !out_stall_i;
  assign in_stall_o  = !adv;
  assign out_valid_o = vld_q[LAT-1];
  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      white_x_q <= WHITE_X_RST;
      white_z_q <= WHITE_Z_RST;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == REG_WHITE_X) white_x_q <= cfg_data_i;
      if (cfg_index_i == REG_WHITE_Z) white_z_q <= cfg_data_i;
    end
  end

  // valid bits alongside the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[LAT-2:0], in_valid_i};
    end
  end

  assign smp[0] = sample_x_i;
  assign smp[1] = sample_y_i;
  assign smp[2] = sample_z_i;
  assign wht[0] = (white_x_q == '0) ? WW'(1) : WW'(white_x_q);
  assign wht[1] = WHITE_Y;
  assign wht[2] = (white_z_q == '0) ? WW'(1) : WW'(white_z_q);

  for (genvar c = 0; c < 3; c++) begin : g_chan
    // stage A: constant products; stage B: branch and divider operands
    always_ff @(posedge clk_i) begin
      if (adv) begin
        s_q[c]     <= smp[c];
        w_q[c]     <= wht[c];
        ps_q[c]    <= 31'(smp[c]) * 31'd24389;
        p216_q[c]  <= (WW+8)'(wht[c]) * (WW+8)'(216);
        p432_q[c]  <= (WW+9)'(wht[c]) * (WW+9)'(432);
        p3132_q[c] <= DW'(wht[c]) * DW'(3132);
        lin_q[c]   <= !(QW'(ps_q[c]) > QW'(p216_q[c]));
        if (QW'(ps_q[c]) > QW'(p216_q[c])) begin
          num_q[c] <= {s_q[c], {(QW-SW){1'b0}}};
          den_q[c] <= DW'(w_q[c]);
        end else begin
          num_q[c] <= (QW'(ps_q[c]) + QW'(p432_q[c])) << 16;
          den_q[c] <= p3132_q[c];
        end
      end
    end

    xtl_div #(.DW(DW)) u_div (
      .clk_i (clk_i),
      .en_i  (adv),
      .num_i (num_q[c]),
      .den_i (den_q[c]),
      .lin_i (lin_q[c]),
      .quo_o (quo[c]),
      .lin_o (dlin[c])
    );

    xtl_cbrt u_cbrt (
      .clk_i (clk_i),
      .en_i  (adv),
      .rad_i (quo[c]),
      .lin_i (dlin[c]),
      .f_o   (f[c])
    );
  end

  xtl_lab #(.FRAC_BITS(FRAC_BITS)) u_lab (
    .clk_i (clk_i),
    .en_i  (adv),
    .fx_i  (f[0]),
    .fy_i  (f[1]),
    .fz_i  (f[2]),
    .l_o   (lightness_o),
    .a_o   (red_green_o),
    .b_o   (yellow_blue_o)
  );

endmodule

>>> hw/rtl/xtl_chk.sv
module xtl_chk import xtl_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input logic [SW-1:0]        sample_x_i,
  input logic [SW-1:0]        sample_y_i,
  input logic [SW-1:0]        sample_z_i,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input logic signed [OW-1:0] lightness_o,
  input logic signed [OW-1:0] red_green_o,
  input logic signed [OW-1:0] yellow_blue_o,
  input logic                 cfg_valid_i,
  input logic                 cfg_ready_o,
  input logic [CFG_IDX_W-1:0] cfg_index_i,
  input logic [SW-1:0]        cfg_data_i
);

  // held result beat stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(lightness_o)
      && $stable(red_green_o) && $stable(yellow_blue_o))
    else $error("result beat changed while stalled");

  // a held result backs up the input side
  a_stall_prop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("input taken while output held");

  // with no held result the input is never refused
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o || !out_stall_i |-> !in_stall_o)
    else $error("input stalled without output back-pressure");

  // configuration writes always complete
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(cfg_valid_i) |-> cfg_ready_o)
    else $error("configuration write refused");

endmodule

bind xyz_to_lab_core xtl_chk u_xtl_chk (.*);

>>> dv/xyz_to_lab_core_tb.sv
module xyz_to_lab_core_tb;
  import xtl_pkg::*;

  localparam int FRAC = 8;
  localparam int DRAIN_CYCLES = 70;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 8'd7;

  typedef struct packed {
    logic signed [OW-1:0] l;
    logic signed [OW-1:0] a;
    logic signed [OW-1:0] b;
  } lab_t;

  // Colour-conversion predictor and the queue of pending Lab results
  class lab_scoreboard;
    logic [SW-1:0] white_x;
    logic [SW-1:0] white_z;
    lab_t          pending_lab[$];
    int            errors;

    function new();
      white_x = WHITE_X_RST;
      white_z = WHITE_Z_RST;
      errors  = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [SW-1:0] data);
      if (idx == REG_WHITE_X) white_x = data;
      else if (idx == REG_WHITE_Z) white_z = data;
    endfunction

    // integer cube root, one root bit per step
    function longint unsigned cube_root(longint unsigned r);
      longint unsigned root, c;
      root = 0;
      for (int bit_i = 21; bit_i >= 0; bit_i--) begin
        c = root | (64'd1 << bit_i);
        if (c <= 64'd2642245 && c * c * c <= r) root = c;
      end
      return root;
    endfunction

    // CIELAB f(s / w) in unsigned Q16
    function longint unsigned lab_f(longint unsigned s, longint unsigned w);
      if (s * 24389 > 216 * w) return cube_root((s << 48) / w);
      return ((s * 24389 + 432 * w) << 16) / (3132 * w);
    endfunction

    // Q16 to FRAC fraction bits, round half up, saturate
    function logic [OW-1:0] round_sat(longint v);
      longint q;
      if (FRAC < 16) q = (v + (64'sd1 <<< (16 - FRAC - 1))) >>> (16 - FRAC);
      else q = v;
      if (q < -32768) q = -32768;
      if (q > 32767) q = 32767;
      return q[OW-1:0];
    endfunction

    function void note_sample(logic [SW-1:0] sx, logic [SW-1:0] sy, logic [SW-1:0] sz);
      longint fx, fy, fz;
      lab_t   e;
      fx = lab_f(sx, (white_x == 0) ? 1 : white_x);
      fy = lab_f(sy, 100 << FRAC);
      fz = lab_f(sz, (white_z == 0) ? 1 : white_z);
      e.l = round_sat(116 * fy - (64'sd16 <<< 16));
      e.a = round_sat(500 * (fx - fy));
      e.b = round_sat(200 * (fy - fz));
      pending_lab.push_back(e);
    endfunction

    function void check_lab(lab_t got);
      lab_t e;
      if (pending_lab.size() == 0) begin
        $display("%0t: unexpected result L=%0d a=%0d b=%0d", $time, got.l, got.a, got.b);
        errors++;
        return;
      end
      e = pending_lab.pop_front();
      if (got.l !== e.l) begin
        $display("%0t: lightness expected %0d got %0d", $time, e.l, got.l);
        errors++;
      end
      if (got.a !== e.a) begin
        $display("%0t: red_green expected %0d got %0d", $time, e.a, got.a);
        errors++;
      end
      if (got.b !== e.b) begin
        $display("%0t: yellow_blue expected %0d got %0d", $time, e.b, got.b);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [SW-1:0] sample_x_i = '0;
  logic [SW-1:0] sample_y_i = '0;
  logic [SW-1:0] sample_z_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [OW-1:0] lightness_o;
  logic signed [OW-1:0] red_green_o;
  logic signed [OW-1:0] yellow_blue_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [SW-1:0] cfg_data_i = '0;

  lab_scoreboard sb = new();
  bit gaps_on = 1'b1;
  bit hold_req = 1'b0;
  int quiet_cycles = 0;

  xyz_to_lab_core #(.FRAC_BITS(FRAC)) DUT (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // mostly short gaps, a few long ones
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // input and output beat monitors
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o)
      sb.note_sample(sample_x_i, sample_y_i, sample_z_i);
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_lab('{lightness_o, red_green_o, yellow_blue_o});
  end

  // watchdog on cycles without any accepted beat or configuration write
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)
        || (cfg_valid_i && cfg_ready_o))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // receiver back-pressure, with one long hold on request
  initial begin
    int n;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        n = gap_len();
        if (n > 0) begin
          out_stall_i <= 1'b1;
          repeat (n) @(posedge clk_i);
        end
      end
      out_stall_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  end

  task automatic send_sample(logic [SW-1:0] sx, logic [SW-1:0] sy, logic [SW-1:0] sz);
    int n;
    n = gap_len();
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_x_i <= sx;
    sample_y_i <= sy;
    sample_z_i <= sz;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sb.pending_lab.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [SW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, data);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // one random field: full range, near the linear/cube-root knee, up to twice white, or masked to a random bit width
  function automatic logic [SW-1:0] rand_field(logic [SW-1:0] white);
    case ($urandom_range(0, 3))
      0: return SW'($urandom_range(0, 65535));
      1: return SW'($urandom_range(0, 600));
      2: return SW'($urandom_range(0, (white < 32768) ? 2 * white + 1 : 65535));
      default: return SW'($urandom_range(0, 65535) & ((17'd1 << $urandom_range(1, 16)) - 1));
    endcase
  endfunction

  task automatic random_phase(int count);
    for (int k = 0; k < count; k++)
      send_sample(rand_field(sb.white_x), rand_field(16'd25600), rand_field(sb.white_z));
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, white point, both sides of the knee
    send_sample(16'd0, 16'd0, 16'd0);
    send_sample(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_sample(16'hFFFF, 16'd0, 16'hFFFF);
    send_sample(16'd0, 16'hFFFF, 16'd0);
    send_sample(WHITE_X_RST, 16'd25600, WHITE_Z_RST);
    send_sample(16'd226, 16'd226, 16'd226);
    send_sample(16'd227, 16'd227, 16'd227);
    send_sample(16'd215, 16'd1, 16'd247);
    send_sample(16'd216, 16'd2, 16'd248);
    send_sample(16'h5555, 16'hAAAA, 16'h5555);
    send_sample(16'hAAAA, 16'h5555, 16'hAAAA);
    send_sample(16'd1, 16'd1, 16'd1);
    random_phase(230);

    // extreme whites, long receiver hold while the sender keeps offering
    wait_drained();
    write_reg(REG_WHITE_X, 16'hFFFF);
    write_reg(REG_WHITE_Z, 16'hFFFF);
    send_sample(16'hFFFF, 16'hFFFF, 16'hFFFF);
    hold_req = 1'b1;
    random_phase(240);

    wait_drained();
    write_reg(REG_WHITE_X, 16'd256);
    write_reg(REG_WHITE_Z, 16'd256);
    send_sample(16'hFFFF, 16'd0, 16'd0);
    send_sample(16'd0, 16'd0, 16'hFFFF);
    random_phase(240);

    // zero white acts as one; stray register index is ignored
    wait_drained();
    write_reg(REG_WHITE_X, 16'd0);
    write_reg(REG_WHITE_Z, 16'd1);
    write_reg(REG_SPARE, 16'h1234);
    send_sample(16'd0, 16'd0, 16'd0);
    send_sample(16'd1, 16'd100, 16'd1);
    random_phase(200);

    // whites below range, no idling on either side
    wait_drained();
    gaps_on = 1'b0;
    write_reg(REG_WHITE_X, SW'($urandom_range(1, 255)));
    write_reg(REG_WHITE_Z, SW'($urandom_range(1, 255)));
    random_phase(200);
    gaps_on = 1'b1;

    for (int p = 0; p < 2; p++) begin
      wait_drained();
      write_reg(REG_WHITE_X, SW'($urandom_range(256, 65535)));
      write_reg(REG_WHITE_Z, SW'($urandom_range(256, 65535)));
      random_phase(210);
    end

    wait_drained();
    if (sb.errors == 0 && sb.pending_lab.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/xtl_pkg.sv
hw/rtl/xtl_div.sv
hw/rtl/xtl_cbrt.sv
hw/rtl/xtl_lab.sv
hw/rtl/xyz_to_lab_core.sv
hw/rtl/xtl_chk.sv
dv/xyz_to_lab_core_tb.sv
